### rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] RegStartByte  = 2'd0;
  localparam logic [1:0] RegEndByte    = 2'd1;
  localparam logic [1:0] RegOwnId      = 2'd2;
  localparam logic [1:0] RegGapTimeout = 2'd3;

  localparam logic [7:0]  StartByteRst  = 8'h02;
  localparam logic [7:0]  EndByteRst    = 8'h03;
  localparam logic [7:0]  OwnIdRst      = 8'h00;
  localparam logic [15:0] GapTimeoutRst = 16'd100;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_BAD     = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_ID   = 4'd1,
    PH_CMD  = 4'd2,
    PH_DIR  = 4'd3,
    PH_ERR  = 4'd4,
    PH_LENL = 4'd5,
    PH_LENH = 4'd6,
    PH_DATA = 4'd7,
    PH_CHK  = 4'd8,
    PH_END  = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  own_id;
    logic [15:0] gap_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  packet_command;
    logic [7:0]  packet_direction;
    logic [7:0]  packet_error;
    logic [15:0] packet_length;
  } res_t;

endpackage

### rtl/fpr_if.sv
// ----------------------------------------------------------------------------
// fpr_if
// Valid/ready channels of the framed packet receiver.
// ----------------------------------------------------------------------------
interface fpr_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface fpr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  packet_command;
  logic [7:0]  packet_direction;
  logic [7:0]  packet_error;
  logic [15:0] packet_length;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output packet_command, output packet_direction, output packet_error,
    output packet_length, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input packet_command, input packet_direction, input packet_error,
    input packet_length, output ready
  );
endinterface

### rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Start/end framed packet parser with XOR check and inter-byte gap timeout.
// ----------------------------------------------------------------------------
// Input channel rx_i carries one item per transfer: a received byte
// (operation 0) or a one millisecond tick (operation 1). Every item yields
// exactly one transfer on res_o: nothing, a payload byte with its index,
// packet good or packet bad; all but the first carry the frame header fields.
// Registers (start byte, end byte, own ID, gap timeout) sit on the APB port
// at byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// An item is held in the input register, is parsed in a single pass and
// lands in the result register, from which res_o offers it; one item is
// taken per cycle while res_o does not stall. When res_o stalls, the input
// register still takes one more item before rx_i.ready drops. Reset returns
// the parser to hunting for the start byte, clears the idle tick counter and
// restores register defaults.
// ----------------------------------------------------------------------------
module framed_packet_receiver import fpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fpr_in_if.sink               rx_i,
  fpr_out_if.source            res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       in_vld_q, in_vld_d;
  logic       out_vld_q, out_vld_d;
  logic [0:0] op_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       in_xfer;

  fpr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = in_vld_q & (~out_vld_q | res_o.ready);
  assign rx_i.ready = ~in_vld_q | advance;
  assign in_xfer    = rx_i.valid & rx_i.ready;

  fpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .operation_i (op_q),
    .rx_byte_i   (byte_q),
    .res_o       (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= rx_i.operation;
      byte_q <= rx_i.rx_byte;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.result_kind      = res_q.result_kind;
  assign res_o.payload_byte     = res_q.payload_byte;
  assign res_o.payload_index    = res_q.payload_index;
  assign res_o.packet_command   = res_q.packet_command;
  assign res_o.packet_direction = res_q.packet_direction;
  assign res_o.packet_error     = res_q.packet_error;
  assign res_o.packet_length    = res_q.packet_length;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register not loaded after advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_o.ready |-> !advance)
    else $error("stalled result overwritten");

  a_full_input_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !res_o.ready |-> !rx_i.ready)
    else $error("input taken while both stages are full");

endmodule

### rtl/fpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpr_cfg_regs
// APB register file: start byte, end byte, own ID and gap timeout.
// ----------------------------------------------------------------------------
module fpr_cfg_regs import fpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegStartByte:  cfg_d.start_byte  = pwdata[7:0];
        RegEndByte:    cfg_d.end_byte    = pwdata[7:0];
        RegOwnId:      cfg_d.own_id      = pwdata[7:0];
        RegGapTimeout: cfg_d.gap_timeout = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegStartByte:  prdata = {24'h0, cfg_q.start_byte};
      RegEndByte:    prdata = {24'h0, cfg_q.end_byte};
      RegOwnId:      prdata = {24'h0, cfg_q.own_id};
      RegGapTimeout: prdata = {16'h0, cfg_q.gap_timeout};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= StartByteRst;
      cfg_q.end_byte    <= EndByteRst;
      cfg_q.own_id      <= OwnIdRst;
      cfg_q.gap_timeout <= GapTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/fpr_parser.sv
// ----------------------------------------------------------------------------
// fpr_parser
// Frame parser state and single-step update for one byte or tick.
// ----------------------------------------------------------------------------
module fpr_parser import fpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [0:0] operation_i,
  input  logic [7:0] rx_byte_i,
  output res_t       res_o
);

  phase_e      phase_q, phase_d, phase_cur;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  dir_q, dir_d;
  logic [7:0]  err_q, err_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] idx_inc;
  logic [15:0] len_new;
  logic        gap_hit;

  assign gap_hit = idle_q >= cfg_i.gap_timeout;
  assign idx_inc = idx_q + 16'd1;
  assign len_new = {rx_byte_i, len_q[7:0]};

  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    chk_d     = chk_q;
    cmd_d     = cmd_q;
    dir_d     = dir_q;
    err_d     = err_q;
    len_d     = len_q;
    idx_d     = idx_q;
    idle_d    = idle_q;
    phase_cur = gap_hit ? PH_HUNT : phase_q;
    res_o     = '0;
    if (step_i) begin
      if (operation_i == OP_TICK) begin
        if (idle_q != 16'hFFFF) begin
          idle_d = idle_q + 16'd1;
        end
      end else begin
        idle_d  = '0;
        phase_d = phase_cur;
        case (phase_cur)
          PH_ID: begin
            if (rx_byte_i == cfg_i.own_id) begin
              xor_d   = xor_q ^ rx_byte_i;
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            cmd_d   = rx_byte_i;
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_DIR;
          end
          PH_DIR: begin
            dir_d   = rx_byte_i;
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_ERR;
          end
          PH_ERR: begin
            err_d   = rx_byte_i;
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_LENL;
          end
          PH_LENL: begin
            len_d   = {8'h00, rx_byte_i};
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_LENH;
          end
          PH_LENH: begin
            len_d = len_new;
            xor_d = xor_q ^ rx_byte_i;
            if (len_new != 16'd0) begin
              idx_d   = '0;
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_CHK;
            end
          end
          PH_DATA: begin
            xor_d                  = xor_q ^ rx_byte_i;
            res_o.result_kind      = KIND_PAYLOAD;
            res_o.payload_byte     = rx_byte_i;
            res_o.payload_index    = idx_q;
            res_o.packet_command   = cmd_q;
            res_o.packet_direction = dir_q;
            res_o.packet_error     = err_q;
            res_o.packet_length    = len_q;
            idx_d                  = idx_inc;
            if (idx_inc == len_q) begin
              phase_d = PH_CHK;
            end
          end
          PH_CHK: begin
            chk_d   = rx_byte_i;
            phase_d = PH_END;
          end
          PH_END: begin
            res_o.result_kind      = ((rx_byte_i == cfg_i.end_byte) && (xor_q == chk_q))
                                     ? KIND_GOOD : KIND_BAD;
            res_o.packet_command   = cmd_q;
            res_o.packet_direction = dir_q;
            res_o.packet_error     = err_q;
            res_o.packet_length    = len_q;
            phase_d                = PH_HUNT;
          end
          default: begin
            phase_d = PH_HUNT;
            if (rx_byte_i == cfg_i.start_byte) begin
              phase_d = PH_ID;
              xor_d   = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      xor_q   <= '0;
      chk_q   <= '0;
      cmd_q   <= '0;
      dir_q   <= '0;
      err_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      idle_q  <= '0;
    end else begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      chk_q   <= chk_d;
      cmd_q   <= cmd_d;
      dir_q   <= dir_d;
      err_q   <= err_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      idle_q  <= idle_d;
    end
  end

  a_tick_keeps_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (operation_i == OP_TICK) |=> $stable(phase_q))
    else $error("tick changed parser phase");

  a_byte_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (operation_i == OP_BYTE) |=> (idle_q == 16'd0))
    else $error("idle counter not cleared by byte");

  a_payload_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.result_kind == KIND_PAYLOAD) |-> (phase_q == PH_DATA) && !gap_hit)
    else $error("payload result outside data phase");

  a_frame_end_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ((res_o.result_kind == KIND_GOOD) || (res_o.result_kind == KIND_BAD))
    |=> (phase_q == PH_HUNT))
    else $error("parser not hunting after frame end");

endmodule
